// File: rtl/cssp_pkg.sv
// ----------------------------------------------------------------------------
// Convex support-point search: shared types and constants
// Item formats, operation and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cssp_pkg;

  // Default sizing of the vertex store and the stored coordinate width.
  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_COORD_BITS   = 16;

  // Fixed widths of the item fields.
  localparam int IN_COORD_W   = 16;
  localparam int OUT_COORD_W  = 16;
  localparam int OUT_INDEX_W  = 6;
  localparam int EPS_W        = 31;

  // A near-set query returns at most this many vertices.
  localparam int RESULT_CAP   = 64;
  localparam int RESULT_CNT_W = 7;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FAR    = 2'd2,
    OP_NEAR   = 2'd3
  } op_e_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_WAIT1,
    S_SCAN2,
    S_WAIT2
  } state_e_t;

  // One input item.
  typedef struct packed {
    op_e_t                        op;
    logic signed [IN_COORD_W-1:0] coord_x;
    logic signed [IN_COORD_W-1:0] coord_y;
    logic signed [IN_COORD_W-1:0] coord_z;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [OUT_COORD_W-1:0] point_x;
    logic signed [OUT_COORD_W-1:0] point_y;
    logic signed [OUT_COORD_W-1:0] point_z;
    logic [OUT_INDEX_W-1:0]        point_index;
    status_e_t                     status;
    logic                          last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      clear;       // empty the store
    logic      append;      // write the incoming vertex at the fill position
    logic      emit_ack;    // send a result with no point
    status_e_t ack_status;
    logic      load_dir;    // capture the query direction, restart the maximum
    logic      scan_start;  // rewind the scan address
    logic      scan_step;   // read one vertex and advance the address
    logic      pass2;       // pipeline output feeds the near-set selection
    logic      pass2_init;  // forget pending near-set results
    logic      emit_best;   // send the farthest vertex
    logic      flush;       // send the held near-set vertex as the last one
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic scan_at_end;
    logic pipe_empty;
  } stat_t;

endpackage

// File: rtl/convex_support_point_search.sv
// ----------------------------------------------------------------------------
// Convex support-point search
// Vertex store with farthest-vertex and near-set queries along a direction.
// ----------------------------------------------------------------------------
// Usage:
//   An item on in_item is taken at a clock edge where start is high and
//   busy is low. Clear, append and a query on an empty store answer with one
//   result in the next cycle and leave busy low, so such items can be sent
//   every cycle.
//   A query scans the N stored vertices through one memory read port, one
//   vertex per cycle, into a three-stage dot product pipeline. A farthest
//   query makes one pass and then returns its result. A near-set query
//   makes a second pass over the store and sends qualifying vertices during
//   it, the final one marked by last; it may send no result at all.
//   Busy stays high for the whole query.
//   Each result is on out_item for one cycle with out_valid high; the
//   receiver cannot stall it.
//   Epsilon is written through cfg_valid/cfg_epsilon; cfg_ready is always
//   high. Write it only while the block is idle.
//   Reset empties the store and clears epsilon; no clearing pass is needed.
// ----------------------------------------------------------------------------
module convex_support_point_search #(
  parameter int MAX_VERTICES = cssp_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = cssp_pkg::DEF_COORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  cssp_pkg::in_item_t          in_item,
  output logic                        out_valid,
  output cssp_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cssp_pkg::EPS_W-1:0]  cfg_epsilon
);

  cssp_pkg::cmd_t  cmd;
  cssp_pkg::stat_t stat;

  // The tolerance register takes a transfer in any cycle.
  assign cfg_ready = 1'b1;

  cssp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_item.op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  cssp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_epsilon (cfg_epsilon),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule

// File: rtl/cssp_ctrl.sv
// ----------------------------------------------------------------------------
// Convex support-point search: controller
// Decodes accepted items, sequences the two scan passes of a query and
// tells the datapath when to send results.
// ----------------------------------------------------------------------------
module cssp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  cssp_pkg::op_e_t  op,
  input  cssp_pkg::stat_t  stat,
  output logic             busy,
  output cssp_pkg::cmd_t   cmd
);

  cssp_pkg::state_e_t state_r, state_nxt;
  logic               near_r, near_nxt;

  // State and query kind registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cssp_pkg::S_IDLE;
      near_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      near_r  <= near_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    near_nxt       = near_r;
    cmd            = '0;
    cmd.ack_status = cssp_pkg::ST_OK;
    unique case (state_r)
      cssp_pkg::S_IDLE: begin
        if (start) begin
          unique case (op)
            cssp_pkg::OP_CLEAR: begin
              cmd.clear    = 1'b1;
              cmd.emit_ack = 1'b1;
            end
            cssp_pkg::OP_APPEND: begin
              cmd.emit_ack = 1'b1;
              if (stat.count_full) begin
                cmd.ack_status = cssp_pkg::ST_FULL;
              end else begin
                cmd.append = 1'b1;
              end
            end
            cssp_pkg::OP_FAR, cssp_pkg::OP_NEAR: begin
              if (stat.count_zero) begin
                cmd.emit_ack   = 1'b1;
                cmd.ack_status = cssp_pkg::ST_EMPTY;
              end else begin
                cmd.load_dir   = 1'b1;
                cmd.scan_start = 1'b1;
                near_nxt       = (op == cssp_pkg::OP_NEAR);
                state_nxt      = cssp_pkg::S_SCAN1;
              end
            end
            default: ;
          endcase
        end
      end
      // First pass: find the maximum dot product.
      cssp_pkg::S_SCAN1: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_at_end) begin
          state_nxt = cssp_pkg::S_WAIT1;
        end
      end
      cssp_pkg::S_WAIT1: begin
        if (stat.pipe_empty) begin
          if (near_r) begin
            cmd.pass2_init = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = cssp_pkg::S_SCAN2;
          end else begin
            cmd.emit_best = 1'b1;
            state_nxt     = cssp_pkg::S_IDLE;
          end
        end
      end
      // Second pass: send every vertex close enough to the maximum, up to the result cap.
      cssp_pkg::S_SCAN2: begin
        cmd.scan_step = 1'b1;
        cmd.pass2     = 1'b1;
        if (stat.scan_at_end) begin
          state_nxt = cssp_pkg::S_WAIT2;
        end
      end
      cssp_pkg::S_WAIT2: begin
        cmd.pass2 = 1'b1;
        if (stat.pipe_empty) begin
          cmd.flush = 1'b1;
          state_nxt = cssp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cssp_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != cssp_pkg::S_IDLE);

  // A scan only starts from idle or between the two passes.
  a_scan_start_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |-> (state_r == cssp_pkg::S_IDLE || state_r == cssp_pkg::S_WAIT1))
    else $error("scan restarted in the middle of a pass");

  // A farthest query never enters the second pass.
  a_far_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cssp_pkg::S_SCAN2) |-> near_r)
    else $error("second pass entered for a farthest query");

  // Busy rises only after a query item is taken.
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(cmd.load_dir))
    else $error("busy rose without a query");

endmodule

// File: rtl/cssp_datapath.sv
// ----------------------------------------------------------------------------
// Convex support-point search: datapath
// Vertex memory, fill count, scan address, a three-stage dot product
// pipeline, the running maximum, near-set selection and the result register.
// ----------------------------------------------------------------------------
module cssp_datapath #(
  parameter int MAX_VERTICES = cssp_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = cssp_pkg::DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cssp_pkg::in_item_t           in_item,
  input  cssp_pkg::cmd_t               cmd,
  output cssp_pkg::stat_t              stat,
  input  logic                         cfg_we,
  input  logic [cssp_pkg::EPS_W-1:0]   cfg_epsilon,
  output logic                         out_valid,
  output cssp_pkg::out_item_t          out_item
);

  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CB    = COORD_BITS;
  localparam int PRD_W = 2 * COORD_BITS;
  localparam int DOT_W = 2 * COORD_BITS + 2;
  localparam int CMP_W = ((DOT_W > 32) ? DOT_W : 32) + 1;
  localparam logic signed [31:0] C_HI = (32'sd1 <<< (COORD_BITS - 1)) - 32'sd1;
  localparam logic signed [31:0] C_LO = -C_HI - 32'sd1;

  // Sign-extend an input coordinate and saturate it to the stored width.
  function automatic logic signed [CB-1:0] sat_coord(
    input logic signed [cssp_pkg::IN_COORD_W-1:0] v
  );
    logic signed [31:0] w;
    w = 32'(v);
    if (w > C_HI) begin
      w = C_HI;
    end else if (w < C_LO) begin
      w = C_LO;
    end
    return CB'(w);
  endfunction

  // Fit a stored coordinate into the result field.
  function automatic logic signed [cssp_pkg::OUT_COORD_W-1:0] out_coord(
    input logic signed [CB-1:0] v
  );
    logic signed [31:0] w;
    w = 32'(v);
    return w[cssp_pkg::OUT_COORD_W-1:0];
  endfunction

  // Fit a store position into the result field.
  function automatic logic [cssp_pkg::OUT_INDEX_W-1:0] out_index(
    input logic [IDX_W-1:0] i
  );
    logic [31:0] w;
    w = 32'(i);
    return w[cssp_pkg::OUT_INDEX_W-1:0];
  endfunction

  // Vertex memory: z, y, x from top to bottom.
  logic [3*CB-1:0] mem [MAX_VERTICES];

  logic [CNT_W-1:0]               count_r;
  logic [IDX_W-1:0]               addr_r;
  logic [cssp_pkg::EPS_W-1:0]     eps_r;
  logic signed [CB-1:0]           dir_x_r, dir_y_r, dir_z_r;

  // Pipeline stages.
  logic                           s1_v_r, s2_v_r, s3_v_r;
  logic [IDX_W-1:0]               s1_idx_r, s2_idx_r, s3_idx_r;
  logic [3*CB-1:0]                s1_data_r;
  logic signed [CB-1:0]           s2_x_r, s2_y_r, s2_z_r;
  logic signed [CB-1:0]           s3_x_r, s3_y_r, s3_z_r;
  logic signed [PRD_W-1:0]        px_r, py_r, pz_r;
  logic signed [DOT_W-1:0]        s3_dot_r;

  // Running maximum and the farthest vertex.
  logic                           best_v_r;
  logic signed [DOT_W-1:0]        maxd_r;
  logic [IDX_W-1:0]               best_idx_r;
  logic signed [CB-1:0]           best_x_r, best_y_r, best_z_r;

  // Held near-set vertex and the number taken so far.
  logic                           pend_v_r;
  logic [IDX_W-1:0]               pend_idx_r;
  logic signed [CB-1:0]           pend_x_r, pend_y_r, pend_z_r;
  logic [cssp_pkg::RESULT_CNT_W-1:0] n_r;

  logic                           out_valid_r;
  cssp_pkg::out_item_t            out_item_r;

  logic                           take_max;
  logic                           qual;
  logic signed [CMP_W-1:0]        near_lhs;

  // Memory write on append and registered read during a scan.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[count_r[IDX_W-1:0]] <= {sat_coord(in_item.coord_z),
                                  sat_coord(in_item.coord_y),
                                  sat_coord(in_item.coord_x)};
    end
    if (cmd.scan_step) begin
      s1_data_r <= mem[addr_r];
    end
  end

  // Fill count, scan address and tolerance register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      addr_r  <= '0;
      eps_r   <= '0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.append) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        addr_r <= '0;
      end else if (cmd.scan_step) begin
        addr_r <= addr_r + IDX_W'(1);
      end
      if (cfg_we) begin
        eps_r <= cfg_epsilon;
      end
    end
  end

  // Query direction.
  always_ff @(posedge clk) begin
    if (cmd.load_dir) begin
      dir_x_r <= sat_coord(in_item.coord_x);
      dir_y_r <= sat_coord(in_item.coord_y);
      dir_z_r <= sat_coord(in_item.coord_z);
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.scan_step;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Pipeline payload: products, then their sum.
  always_ff @(posedge clk) begin
    s1_idx_r <= addr_r;
    s2_idx_r <= s1_idx_r;
    s2_x_r   <= s1_data_r[CB-1:0];
    s2_y_r   <= s1_data_r[2*CB-1:CB];
    s2_z_r   <= s1_data_r[3*CB-1:2*CB];
    px_r     <= $signed(s1_data_r[CB-1:0]) * dir_x_r;
    py_r     <= $signed(s1_data_r[2*CB-1:CB]) * dir_y_r;
    pz_r     <= $signed(s1_data_r[3*CB-1:2*CB]) * dir_z_r;
    s3_idx_r <= s2_idx_r;
    s3_x_r   <= s2_x_r;
    s3_y_r   <= s2_y_r;
    s3_z_r   <= s2_z_r;
    s3_dot_r <= DOT_W'(px_r) + DOT_W'(py_r) + DOT_W'(pz_r);
  end

  // First pass keeps the earliest vertex with the greatest dot product.
  assign take_max = s3_v_r && !cmd.pass2 && (!best_v_r || (s3_dot_r > maxd_r));

  // Second pass takes a vertex when dot + epsilon exceeds the maximum.
  assign near_lhs = CMP_W'(s3_dot_r) + CMP_W'($signed({1'b0, eps_r}));
  assign qual     = s3_v_r && cmd.pass2
                    && (n_r != cssp_pkg::RESULT_CNT_W'(cssp_pkg::RESULT_CAP))
                    && (near_lhs > CMP_W'(maxd_r));

  // Maximum and near-set control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_v_r <= 1'b0;
      pend_v_r <= 1'b0;
      n_r      <= '0;
    end else begin
      if (cmd.load_dir) begin
        best_v_r <= 1'b0;
      end else if (take_max) begin
        best_v_r <= 1'b1;
      end
      if (cmd.pass2_init || cmd.flush) begin
        pend_v_r <= 1'b0;
      end else if (qual) begin
        pend_v_r <= 1'b1;
      end
      if (cmd.pass2_init) begin
        n_r <= '0;
      end else if (qual) begin
        n_r <= n_r + cssp_pkg::RESULT_CNT_W'(1);
      end
    end
  end

  // Maximum and held vertex payload.
  always_ff @(posedge clk) begin
    if (take_max) begin
      maxd_r     <= s3_dot_r;
      best_idx_r <= s3_idx_r;
      best_x_r   <= s3_x_r;
      best_y_r   <= s3_y_r;
      best_z_r   <= s3_z_r;
    end
    if (qual) begin
      pend_idx_r <= s3_idx_r;
      pend_x_r   <= s3_x_r;
      pend_y_r   <= s3_y_r;
      pend_z_r   <= s3_z_r;
    end
  end

  // Result strobe: one cycle per result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_ack || cmd.emit_best
                     || (qual && pend_v_r) || (cmd.flush && pend_v_r);
    end
  end

  // Result payload. A held vertex goes out with last low when a newer one
  // replaces it, and with last high when the pass ends.
  always_ff @(posedge clk) begin
    if (cmd.emit_ack) begin
      out_item_r.point_x     <= '0;
      out_item_r.point_y     <= '0;
      out_item_r.point_z     <= '0;
      out_item_r.point_index <= '0;
      out_item_r.status      <= cmd.ack_status;
      out_item_r.last        <= 1'b1;
    end else if (cmd.emit_best) begin
      out_item_r.point_x     <= out_coord(best_x_r);
      out_item_r.point_y     <= out_coord(best_y_r);
      out_item_r.point_z     <= out_coord(best_z_r);
      out_item_r.point_index <= out_index(best_idx_r);
      out_item_r.status      <= cssp_pkg::ST_OK;
      out_item_r.last        <= 1'b1;
    end else if ((qual || cmd.flush) && pend_v_r) begin
      out_item_r.point_x     <= out_coord(pend_x_r);
      out_item_r.point_y     <= out_coord(pend_y_r);
      out_item_r.point_z     <= out_coord(pend_z_r);
      out_item_r.point_index <= out_index(pend_idx_r);
      out_item_r.status      <= cssp_pkg::ST_OK;
      out_item_r.last        <= cmd.flush;
    end
  end

  assign stat.count_zero  = (count_r == '0);
  assign stat.count_full  = (count_r == CNT_W'(MAX_VERTICES));
  assign stat.scan_at_end = (addr_r == IDX_W'(count_r - CNT_W'(1)));
  assign stat.pipe_empty  = !(s1_v_r || s2_v_r || s3_v_r);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  // An append advances the count by exactly one.
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("append did not advance the count");

  // A scan never reads past the filled part of the store.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> CNT_W'(addr_r) < count_r)
    else $error("scan read an unfilled entry");

  // Ending a pass with a held vertex sends it marked as last.
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush && pend_v_r |=> out_valid_r && out_item_r.last)
    else $error("held near-set vertex not sent as last");

endmodule
